@@ rtl/core/plpmr_pkg.sv @@
// ----------------------------------------------------------------------------
// plpmr_pkg
// Shared widths for the longest positional match run block.
// ----------------------------------------------------------------------------
package plpmr_pkg;

    // symbol width of one input word
    localparam int SYM_W = 8;

    // width of the reported run length
    localparam int OUT_W = 11;

endpackage

@@ rtl/core/pairwise_longest_positional_match_run_top.sv @@
// ----------------------------------------------------------------------------
// pairwise_longest_positional_match_run_top
// Longest run of equal positions over all pairs of a loaded sequence set.
// ----------------------------------------------------------------------------
// Input words load one per cycle while tready is high: each carries a
// symbol (tuser[0] marks it present, tuser[1] closes the sequence) and
// tlast ends the set. After the word with tlast the loader holds tready
// low while the engine compares every pair of stored sequences, one
// position per cycle from a dual-read symbol memory. The result word (run
// length, overflow in tuser) is then registered in the output register
// at the edge that raises m_tvalid, and loading of the next set resumes
// at that same edge; a result that is still waiting holds the engine
// until the receiver takes it.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pairwise_longest_positional_match_run_top
    import plpmr_pkg::*;
#(
    parameter int MAX_SEQS = 16,
    parameter int MAX_LEN  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [0] symbol_valid, [1] end_of_sequence
    input  logic        s_tlast,   // end_of_set
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] longest_run, zero padded
    output logic        m_tuser    // [0] overflow
);

    localparam int CW   = $clog2(MAX_SEQS + 1);
    localparam int IW   = $clog2(MAX_SEQS);
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int SD   = MAX_SEQS * MAX_LEN;
    localparam int AW   = $clog2(SD);
    localparam int TD_W = 16;

    logic             sym_we;
    logic [AW-1:0]    sym_waddr;
    logic [SYM_W-1:0] sym_wdata;
    logic [AW-1:0]    sym_raddr_a, sym_raddr_b;
    logic [SYM_W-1:0] sym_rdata_a, sym_rdata_b;
    logic             len_we;
    logic [IW-1:0]    len_waddr;
    logic [LW-1:0]    len_wdata;
    logic [IW-1:0]    len_raddr_a, len_raddr_b;
    logic [LW-1:0]    len_rdata_a, len_rdata_b;
    logic             fj_valid, fj_ready;
    logic [CW:0]      fj_data;
    logic             bj_valid, bj_ready;
    logic [CW:0]      bj_data;
    logic             release_store;
    logic [OUT_W-1:0] res_run;
    logic             res_ovf;

    // loader
    plpmr_front #(
        .MAX_SEQS (MAX_SEQS),
        .MAX_LEN  (MAX_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .sym_we        (sym_we),
        .sym_waddr     (sym_waddr),
        .sym_wdata     (sym_wdata),
        .len_we        (len_we),
        .len_waddr     (len_waddr),
        .len_wdata     (len_wdata),
        .job_valid     (fj_valid),
        .job_ready     (fj_ready),
        .job_data      (fj_data),
        .release_store (release_store)
    );

    // job queue
    plpmr_queue #(
        .WIDTH (CW + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_data   (fj_data),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_data  (bj_data)
    );

    // symbol store
    plpmr_ram #(
        .WIDTH (SYM_W),
        .DEPTH (SD)
    ) u_sym_ram (
        .aclk    (aclk),
        .we      (sym_we),
        .waddr   (sym_waddr),
        .wdata   (sym_wdata),
        .raddr_a (sym_raddr_a),
        .rdata_a (sym_rdata_a),
        .raddr_b (sym_raddr_b),
        .rdata_b (sym_rdata_b)
    );

    // sequence length store
    plpmr_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_SEQS)
    ) u_len_ram (
        .aclk    (aclk),
        .we      (len_we),
        .waddr   (len_waddr),
        .wdata   (len_wdata),
        .raddr_a (len_raddr_a),
        .rdata_a (len_rdata_a),
        .raddr_b (len_raddr_b),
        .rdata_b (len_rdata_b)
    );

    // comparison engine
    plpmr_back #(
        .MAX_SEQS (MAX_SEQS),
        .MAX_LEN  (MAX_LEN)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (bj_valid),
        .job_ready     (bj_ready),
        .job_data      (bj_data),
        .len_raddr_a   (len_raddr_a),
        .len_rdata_a   (len_rdata_a),
        .len_raddr_b   (len_raddr_b),
        .len_rdata_b   (len_rdata_b),
        .sym_raddr_a   (sym_raddr_a),
        .sym_rdata_a   (sym_rdata_a),
        .sym_raddr_b   (sym_raddr_b),
        .sym_rdata_b   (sym_rdata_b),
        .release_store (release_store),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .res_run       (res_run),
        .res_ovf       (res_ovf)
    );

    // result word packing
    assign m_tdata = {{(TD_W - OUT_W){1'b0}}, res_run};
    assign m_tuser = res_ovf;

endmodule

@@ rtl/core/plpmr_ram.sv @@
// ----------------------------------------------------------------------------
// plpmr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module plpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/plpmr_front.sv @@
// ----------------------------------------------------------------------------
// plpmr_front
// Loader: takes input words, writes symbols and sequence lengths to memory
// and hands a finished set to the comparison engine as a job.
// ----------------------------------------------------------------------------
module plpmr_front
    import plpmr_pkg::*;
#(
    parameter int MAX_SEQS = 16,
    parameter int MAX_LEN  = 1024,
    localparam int CW = $clog2(MAX_SEQS + 1),
    localparam int IW = $clog2(MAX_SEQS),
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int AW = $clog2(MAX_SEQS * MAX_LEN)
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] symbol
    input  logic [1:0]       s_tuser,   // [0] symbol_valid, [1] end_of_sequence
    input  logic             s_tlast,   // end_of_set
    // symbol store write
    output logic             sym_we,
    output logic [AW-1:0]    sym_waddr,
    output logic [SYM_W-1:0] sym_wdata,
    // length store write
    output logic             len_we,
    output logic [IW-1:0]    len_waddr,
    output logic [LW-1:0]    len_wdata,
    // job hand-off: {overflow, count}
    output logic             job_valid,
    input  logic             job_ready,
    output logic [CW:0]      job_data,
    // store released by the engine
    input  logic             release_store
);

    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [LW-1:0] wp_reg,   wp_next;
    logic [AW-1:0] base_reg, base_next;
    logic          ovf_reg,  ovf_next;
    logic          busy_reg, busy_next;

    logic          accept;
    logic          room;
    logic          store_ok;
    logic [LW-1:0] wp_inc;
    logic          close_seq;

    assign s_tready = !busy_reg && job_ready;
    assign accept   = s_tvalid && s_tready;

    // storage decisions for this word
    assign room      = cnt_reg < CW'(MAX_SEQS);
    assign store_ok  = s_tuser[0] && room && (wp_reg < LW'(MAX_LEN));
    assign wp_inc    = wp_reg + LW'(store_ok);
    assign close_seq = s_tuser[1] || (s_tlast && (wp_inc != '0));

    assign sym_we    = accept && store_ok;
    assign sym_waddr = base_reg + AW'(wp_reg);
    assign sym_wdata = s_tdata;

    assign len_we    = accept && close_seq && room;
    assign len_waddr = cnt_reg[IW-1:0];
    assign len_wdata = wp_inc;

    // loading state update
    always_comb begin
        logic [CW-1:0] cnt_c;
        logic          ovf_c;
        cnt_c     = cnt_reg;
        ovf_c     = ovf_reg;
        cnt_next  = cnt_reg;
        wp_next   = wp_reg;
        base_next = base_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        job_valid = 1'b0;
        if (release_store) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            if (s_tuser[0] && !store_ok) begin
                ovf_c = 1'b1;
            end
            if (close_seq) begin
                if (room) begin
                    cnt_c     = cnt_reg + CW'(1);
                    base_next = base_reg + AW'(MAX_LEN);
                end else begin
                    ovf_c = 1'b1;
                end
                wp_next = '0;
            end else begin
                wp_next = wp_inc;
            end
            cnt_next = cnt_c;
            ovf_next = ovf_c;
            if (s_tlast) begin
                job_valid = 1'b1;
                cnt_next  = '0;
                wp_next   = '0;
                base_next = '0;
                ovf_next  = 1'b0;
                busy_next = 1'b1;
            end
        end
        job_data = {ovf_c, cnt_c};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            wp_reg   <= '0;
            base_reg <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            wp_reg   <= wp_next;
            base_reg <= base_next;
            ovf_reg  <= ovf_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ rtl/core/plpmr_queue.sv @@
// ----------------------------------------------------------------------------
// plpmr_queue
// Two-entry job queue between loader and comparison engine.
// ----------------------------------------------------------------------------
module plpmr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg,   fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = fill_reg != 2'd2;
    assign out_valid = fill_reg != 2'd0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/plpmr_back.sv @@
// ----------------------------------------------------------------------------
// plpmr_back
// Comparison engine: walks every pair of stored sequences and keeps the
// longest run of equal positions, then presents the result word.
// ----------------------------------------------------------------------------
module plpmr_back
    import plpmr_pkg::*;
#(
    parameter int MAX_SEQS = 16,
    parameter int MAX_LEN  = 1024,
    localparam int CW = $clog2(MAX_SEQS + 1),
    localparam int IW = $clog2(MAX_SEQS),
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int AW = $clog2(MAX_SEQS * MAX_LEN)
) (
    input  logic             aclk,
    input  logic             aresetn,
    // job from queue: {overflow, count}
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [CW:0]      job_data,
    // length store reads
    output logic [IW-1:0]    len_raddr_a,
    input  logic [LW-1:0]    len_rdata_a,
    output logic [IW-1:0]    len_raddr_b,
    input  logic [LW-1:0]    len_rdata_b,
    // symbol store reads
    output logic [AW-1:0]    sym_raddr_a,
    input  logic [SYM_W-1:0] sym_rdata_a,
    output logic [AW-1:0]    sym_raddr_b,
    input  logic [SYM_W-1:0] sym_rdata_b,
    // store free for the next set
    output logic             release_store,
    // result
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] res_run,
    output logic             res_ovf
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_LENW = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_PAIR = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg,   cnt_next;
    logic             ovf_reg,   ovf_next;
    logic [CW-1:0]    i_reg,     i_next;
    logic [CW-1:0]    j_reg,     j_next;
    logic [AW-1:0]    ibase_reg, ibase_next;
    logic [AW-1:0]    jbase_reg, jbase_next;
    logic [AW-1:0]    pa_reg,    pa_next;
    logic [AW-1:0]    pb_reg,    pb_next;
    logic [LW-1:0]    k_reg,     k_next;
    logic [LW-1:0]    n_reg,     n_next;
    logic [LW-1:0]    run_reg,   run_next;
    logic [LW-1:0]    best_reg,  best_next;
    logic             rdv_reg,   rdv_next;
    logic             mval_reg,  mval_next;
    logic [OUT_W-1:0] rrun_reg,  rrun_next;
    logic             rovf_reg,  rovf_next;

    logic [CW-1:0]    job_cnt;
    logic             job_ovf;

    assign job_cnt = job_data[CW-1:0];
    assign job_ovf = job_data[CW];

    assign job_ready   = state_reg == ST_IDLE;
    assign len_raddr_a = i_reg[IW-1:0];
    assign len_raddr_b = j_reg[IW-1:0];
    assign sym_raddr_a = pa_reg;
    assign sym_raddr_b = pb_reg;
    assign m_tvalid    = mval_reg;
    assign res_run     = rrun_reg;
    assign res_ovf     = rovf_reg;

    // sequencer
    always_comb begin
        logic [LW-1:0] run_c;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ibase_next    = ibase_reg;
        jbase_next    = jbase_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        run_next      = run_reg;
        best_next     = best_reg;
        rdv_next      = 1'b0;
        mval_next     = mval_reg && !m_tready;
        rrun_next     = rrun_reg;
        rovf_next     = rovf_reg;
        release_store = 1'b0;

        // compare the symbol pair read last cycle
        run_c = (sym_rdata_a == sym_rdata_b) ? run_reg + LW'(1) : '0;
        if (rdv_reg) begin
            run_next = run_c;
            if (run_c > best_reg) begin
                best_next = run_c;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    cnt_next   = job_cnt;
                    ovf_next   = job_ovf;
                    i_next     = '0;
                    j_next     = CW'(1);
                    ibase_next = '0;
                    jbase_next = AW'(MAX_LEN);
                    best_next  = '0;
                    state_next = (job_cnt < CW'(2)) ? ST_OUT : ST_LEN;
                end
            end
            ST_LEN: begin
                state_next = ST_LENW;
            end
            ST_LENW: begin
                n_next     = (len_rdata_a < len_rdata_b) ? len_rdata_a : len_rdata_b;
                k_next     = '0;
                run_next   = '0;
                pa_next    = ibase_reg;
                pb_next    = jbase_reg;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (k_reg < n_reg) begin
                    rdv_next = 1'b1;
                    k_next   = k_reg + LW'(1);
                    pa_next  = pa_reg + AW'(1);
                    pb_next  = pb_reg + AW'(1);
                end else if (!rdv_reg) begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (j_reg + CW'(1) < cnt_reg) begin
                    j_next     = j_reg + CW'(1);
                    jbase_next = jbase_reg + AW'(MAX_LEN);
                    state_next = ST_LEN;
                end else if (i_reg + CW'(2) < cnt_reg) begin
                    i_next     = i_reg + CW'(1);
                    j_next     = i_reg + CW'(2);
                    ibase_next = ibase_reg + AW'(MAX_LEN);
                    jbase_next = ibase_reg + AW'(2 * MAX_LEN);
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next     = 1'b1;
                    rrun_next     = OUT_W'(best_reg);
                    rovf_next     = ovf_reg;
                    release_store = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rdv_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            mval_reg  <= mval_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        ovf_reg   <= ovf_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        ibase_reg <= ibase_next;
        jbase_reg <= jbase_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        run_reg   <= run_next;
        best_reg  <= best_next;
        rrun_reg  <= rrun_next;
        rovf_reg  <= rovf_next;
    end

endmodule
